/* rtl/core/level_priority_scheduler_macros.svh */
// Assertion helpers used by the scheduler top module.
`ifndef LEVEL_PRIORITY_SCHEDULER_MACROS_SVH
`define LEVEL_PRIORITY_SCHEDULER_MACROS_SVH

// Checked on every clock edge outside of reset.
`define LPS_ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LPS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/lps_pkg.sv */
package lps_pkg;

  localparam int ID_W  = 6;
  localparam int LVL_W = 7;
  localparam int ORD_W = 32;

  localparam int NUM_ENTRIES_DEF     = 64;
  localparam int MAX_LEVEL_DEF       = 100;
  localparam int CMD_QUEUE_DEPTH_DEF = 2;

  localparam logic [LVL_W-1:0] FLOOR_RESET = 7'd30;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_IDX_FLOOR = 1'b0;

  typedef enum logic [1:0] {
    REQ_ARRIVE = 2'd0,
    REQ_RAISE  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_code_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ID_W-1:0]  entry_id;
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] increment;
  } req_t;

  typedef struct packed {
    logic            status;
    logic [ID_W-1:0] served_id;
  } rsp_t;

  // Classified command passed from the front end to the execution unit.
  typedef struct packed {
    req_code_t        op;
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] increment;
  } cmd_t;

  // One table entry as stored in the entry RAM.
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [ORD_W-1:0] ord;
  } entry_t;

  typedef struct packed {
    logic scan_busy;
    logic in_result;
  } bk_stat_t;

endpackage

/* rtl/core/lps_stream_if.sv */
interface lps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/level_priority_scheduler.sv */
// Priority scheduler over a table of NUM_ENTRIES waiting entries indexed by entry id.
// Requests enter on in_chan and are classified into a short command queue; the execution
// unit behind it keeps levels and arrival numbers in a single-port-read entry RAM and the
// waiting flags in flip-flops. Arrive and remove complete in the execution unit's idle state;
// raise reads the entry, then writes it back in a raise state. A query walks the RAM one entry
// per cycle, over NUM_ENTRIES entries (at most 64), and returns one beat on out_chan;
// the other requests return nothing. A finished result waits in the output register
// while the next requests are accepted. The floor min_served_level is written through
// the APB port at byte address 0 and resets to 30; write it only while the block is idle.
`include "level_priority_scheduler_macros.svh"

module level_priority_scheduler #(
  parameter int NUM_ENTRIES     = lps_pkg::NUM_ENTRIES_DEF,
  parameter int MAX_LEVEL       = lps_pkg::MAX_LEVEL_DEF,
  parameter int CMD_QUEUE_DEPTH = lps_pkg::CMD_QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lps_stream_if.sink                  in_chan,
  lps_stream_if.source                out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lps_pkg::CFG_AW-1:0]  paddr,
  input  logic [lps_pkg::CFG_DW-1:0]  pwdata,
  output logic [lps_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  logic [lps_pkg::LVL_W-1:0] floor_r;
  logic                      floor_sel;

  logic                      q_push;
  lps_pkg::cmd_t             q_push_cmd;
  logic                      q_full;
  logic                      cmd_pop;
  logic                      cmd_valid;
  lps_pkg::cmd_t             cmd;
  lps_pkg::rsp_t             rsp;
  lps_pkg::bk_stat_t         bk_stat;

  assign floor_sel = paddr[lps_pkg::CFG_AW-1:2] == lps_pkg::REG_IDX_FLOOR;
  assign pready    = 1'b1;
  assign prdata    = floor_sel ? lps_pkg::CFG_DW'(floor_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= lps_pkg::FLOOR_RESET;
    end else if (psel && penable && pwrite && floor_sel) begin
      floor_r <= pwdata[lps_pkg::LVL_W-1:0];
    end
  end

  lps_front #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_LEVEL   (MAX_LEVEL)
  ) u_front (
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  lps_cmd_queue #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .pop_cmd  (cmd)
  );

  lps_back #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_LEVEL   (MAX_LEVEL)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .floor_lvl (floor_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp_valid (out_chan.valid),
    .rsp_ready (out_chan.ready),
    .rsp       (rsp),
    .stat      (bk_stat)
  );

  assign out_chan.payload = rsp;

  `LPS_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_chan.valid, "beat after reset")
  `LPS_ASSERT_CLK(a_no_pop_in_scan, bk_stat.scan_busy |-> !cmd_pop, "pop during scan")
  `LPS_ASSERT_CLK(a_scan_beat, $rose(out_chan.valid) |-> $past(bk_stat.in_result), "stray beat")
endmodule

/* rtl/core/lps_ram.sv */
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* rtl/core/lps_front.sv */
module lps_front #(
  parameter int NUM_ENTRIES = lps_pkg::NUM_ENTRIES_DEF,
  parameter int MAX_LEVEL   = lps_pkg::MAX_LEVEL_DEF
) (
  lps_stream_if.sink    in_chan,
  input  logic          q_full,
  output logic          push,
  output lps_pkg::cmd_t push_cmd
);
  lps_pkg::req_code_t op;
  logic               id_ok;
  logic               keep;

  assign op    = lps_pkg::req_code_t'(in_chan.payload.req_type);
  assign id_ok = 32'(in_chan.payload.entry_id) < 32'(NUM_ENTRIES);

  // Updates to ids beyond the table are dropped here; queries always pass.
  assign keep = (op == lps_pkg::REQ_QUERY) || id_ok;

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full && keep;

  always_comb begin
    push_cmd.op        = op;
    push_cmd.id        = in_chan.payload.entry_id;
    push_cmd.increment = in_chan.payload.increment;
    if (32'(in_chan.payload.level) > 32'(MAX_LEVEL)) begin
      push_cmd.level = lps_pkg::LVL_W'(MAX_LEVEL);
    end else begin
      push_cmd.level = in_chan.payload.level;
    end
  end
endmodule

/* rtl/core/lps_cmd_queue.sv */
module lps_cmd_queue #(
  parameter int DEPTH = lps_pkg::CMD_QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lps_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output lps_pkg::cmd_t pop_cmd
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lps_pkg::cmd_t  slots_r [DEPTH];
  logic [PW-1:0]  wptr_r;
  logic [PW-1:0]  rptr_r;
  logic [CW-1:0]  count_r;

  assign full    = count_r == CW'(DEPTH);
  assign valid   = count_r != '0;
  assign pop_cmd = slots_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        slots_r[wptr_r] <= push_cmd;
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end
endmodule

/* rtl/core/lps_back.sv */
module lps_back #(
  parameter int NUM_ENTRIES = lps_pkg::NUM_ENTRIES_DEF,
  parameter int MAX_LEVEL   = lps_pkg::MAX_LEVEL_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lps_pkg::LVL_W-1:0] floor_lvl,
  input  logic                      cmd_valid,
  input  lps_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output lps_pkg::rsp_t             rsp,
  output lps_pkg::bk_stat_t         stat
);
  localparam int ID_SPAN = 2 ** lps_pkg::ID_W;
  localparam int DEPTH   = (NUM_ENTRIES < ID_SPAN) ? NUM_ENTRIES : ID_SPAN;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ENT_W   = $bits(lps_pkg::entry_t);
  localparam int LW      = lps_pkg::LVL_W;
  localparam int OW      = lps_pkg::ORD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAISE,
    ST_SCAN,
    ST_FINISH,
    ST_RESULT
  } state_t;

  state_t              state_r;
  logic [DEPTH-1:0]    flags_r;
  logic [OW-1:0]       next_order_r;
  logic [ADDR_W-1:0]   raise_id_r;
  logic [LW-1:0]       raise_inc_r;
  logic [ADDR_W-1:0]   scan_cnt_r;
  logic                cmp_vld_r;
  logic                cmp_flag_r;
  logic [ADDR_W-1:0]   cmp_idx_r;
  logic                found_r;
  logic [ADDR_W-1:0]   best_id_r;
  logic [LW-1:0]       best_lvl_r;
  logic [OW-1:0]       best_ord_r;
  logic                rsp_valid_r;
  lps_pkg::rsp_t       rsp_r;

  logic [ADDR_W-1:0]   cmd_addr;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  lps_pkg::entry_t     ram_wentry;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;
  lps_pkg::entry_t     cur;
  logic [LW:0]         raise_sum;
  logic [LW-1:0]       raise_lvl_nxt;
  logic                cmp_hit;
  logic                out_free;

  assign cmd_addr = cmd.id[ADDR_W-1:0];
  assign cmd_pop  = (state_r == ST_IDLE) && cmd_valid;
  assign cur      = lps_pkg::entry_t'(ram_rdata);
  assign out_free = !rsp_valid_r || rsp_ready;

  assign raise_sum     = {1'b0, cur.lvl} + {1'b0, raise_inc_r};
  assign raise_lvl_nxt = (32'(raise_sum) > 32'(MAX_LEVEL)) ? LW'(MAX_LEVEL)
                                                           : raise_sum[LW-1:0];

  // Ascending scan with a strict order compare, so equal orders keep the lowest id.
  assign cmp_hit = cmp_flag_r && (cur.lvl >= floor_lvl) &&
                   (!found_r || (cur.lvl > best_lvl_r) ||
                    ((cur.lvl == best_lvl_r) && (cur.ord < best_ord_r)));

  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = cmd_addr;
    ram_wentry.lvl = cmd.level;
    ram_wentry.ord = next_order_r;
    if (cmd_pop && (cmd.op == lps_pkg::REQ_ARRIVE)) begin
      ram_we = 1'b1;
    end else if (state_r == ST_RAISE) begin
      ram_we         = 1'b1;
      ram_waddr      = raise_id_r;
      ram_wentry.lvl = raise_lvl_nxt;
      ram_wentry.ord = cur.ord;
    end
  end

  assign ram_raddr = (state_r == ST_SCAN) ? scan_cnt_r : cmd_addr;

  lps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENT_W'(ram_wentry)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      flags_r      <= '0;
      next_order_r <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      rsp_valid_r  <= 1'b0;
    end else begin
      cmp_vld_r <= (state_r == ST_SCAN);

      // A new result may load in the same cycle as the old beat leaves.
      if ((state_r == ST_RESULT) && out_free) begin
        rsp_valid_r <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid_r <= 1'b0;
      end

      if (cmp_vld_r && cmp_hit) begin
        found_r    <= 1'b1;
        best_id_r  <= cmp_idx_r;
        best_lvl_r <= cur.lvl;
        best_ord_r <= cur.ord;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              lps_pkg::REQ_ARRIVE: begin
                flags_r[cmd_addr] <= 1'b1;
                if (next_order_r != '1) begin
                  next_order_r <= next_order_r + 1'b1;
                end
              end
              lps_pkg::REQ_RAISE: begin
                if (flags_r[cmd_addr]) begin
                  raise_id_r  <= cmd_addr;
                  raise_inc_r <= cmd.increment;
                  state_r     <= ST_RAISE;
                end
              end
              lps_pkg::REQ_REMOVE: begin
                flags_r[cmd_addr] <= 1'b0;
              end
              lps_pkg::REQ_QUERY: begin
                scan_cnt_r <= '0;
                found_r    <= 1'b0;
                state_r    <= ST_SCAN;
              end
            endcase
          end
        end
        ST_RAISE: begin
          state_r <= ST_IDLE;
        end
        ST_SCAN: begin
          cmp_idx_r  <= scan_cnt_r;
          cmp_flag_r <= flags_r[scan_cnt_r];
          scan_cnt_r <= scan_cnt_r + 1'b1;
          if (scan_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            rsp_r.status    <= !found_r;
            rsp_r.served_id <= found_r ? lps_pkg::ID_W'(best_id_r) : '0;
            state_r         <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_valid      = rsp_valid_r;
  assign rsp            = rsp_r;
  assign stat.scan_busy = (state_r == ST_SCAN) || (state_r == ST_FINISH) ||
                          (state_r == ST_RESULT);
  assign stat.in_result = state_r == ST_RESULT;
endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int NUM_IDS       = lps_pkg::NUM_ENTRIES_DEF;
  localparam int MAX_LVL       = lps_pkg::MAX_LEVEL_DEF;
  localparam int SETTLE_CYCLES = lps_pkg::NUM_ENTRIES_DEF + 16;
  localparam int PHASE_ITEMS   = 130;
  localparam int NUM_PHASES    = 6;
  localparam int LW            = lps_pkg::LVL_W;
  localparam int OW            = lps_pkg::ORD_W;
  localparam int IW            = lps_pkg::ID_W;

  // Mirror of the scheduler table: tracks waiting entries and predicts query answers.
  class waiting_table;
    bit              waiting [NUM_IDS];
    logic [LW-1:0]   lvl_of  [NUM_IDS];
    logic [OW-1:0]   ord_of  [NUM_IDS];
    logic [OW-1:0]   next_ord;
    logic [LW-1:0]   floor_lvl;
    lps_pkg::rsp_t   served_q[$];
    int              bad_beats;
    int              n_arrive, n_raise, n_remove, n_found, n_empty, n_checked;

    function new();
      foreach (waiting[i]) begin
        waiting[i] = 1'b0;
        lvl_of[i]  = '0;
        ord_of[i]  = '0;
      end
      next_ord  = '0;
      floor_lvl = lps_pkg::FLOOR_RESET;
    endfunction

    function logic [LW-1:0] cap_lvl(int unsigned v);
      return (v > MAX_LVL) ? LW'(MAX_LVL) : LW'(v);
    endfunction

    function lps_pkg::rsp_t best_waiting();
      lps_pkg::rsp_t ans;
      bit            found;
      logic [LW-1:0] best_lvl;
      logic [OW-1:0] best_ord;
      found    = 1'b0;
      best_lvl = '0;
      best_ord = '0;
      ans.status    = 1'b1;
      ans.served_id = '0;
      for (int i = 0; i < NUM_IDS; i++) begin
        if (waiting[i] && lvl_of[i] >= floor_lvl) begin
          if (!found || lvl_of[i] > best_lvl ||
              (lvl_of[i] == best_lvl && ord_of[i] < best_ord)) begin
            found         = 1'b1;
            best_lvl      = lvl_of[i];
            best_ord      = ord_of[i];
            ans.status    = 1'b0;
            ans.served_id = IW'(i);
          end
        end
      end
      return ans;
    endfunction

    function void apply_request(lps_pkg::req_t r);
      lps_pkg::rsp_t ans;
      case (lps_pkg::req_code_t'(r.req_type))
        lps_pkg::REQ_ARRIVE: begin
          waiting[r.entry_id] = 1'b1;
          lvl_of[r.entry_id]  = cap_lvl(r.level);
          ord_of[r.entry_id]  = next_ord;
          // The arrival counter sticks at its top value instead of wrapping.
          if (next_ord != '1) next_ord++;
          n_arrive++;
        end
        lps_pkg::REQ_RAISE: begin
          if (waiting[r.entry_id])
            lvl_of[r.entry_id] = cap_lvl(int'(lvl_of[r.entry_id]) + int'(r.increment));
          n_raise++;
        end
        lps_pkg::REQ_REMOVE: begin
          waiting[r.entry_id] = 1'b0;
          n_remove++;
        end
        lps_pkg::REQ_QUERY: begin
          ans = best_waiting();
          served_q.push_back(ans);
          if (ans.status) n_empty++;
          else n_found++;
        end
      endcase
    endfunction

    function void check_served(lps_pkg::rsp_t got);
      lps_pkg::rsp_t want;
      if (served_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("%0t: unexpected result beat status=%0d id=%0d",
                   $realtime, got.status, got.served_id);
        return;
      end
      want = served_q.pop_front();
      n_checked++;
      if (got.status !== want.status || got.served_id !== want.served_id) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("%0t: result mismatch: expected status=%0d id=%0d, got status=%0d id=%0d",
                   $realtime, want.status, want.served_id, got.status, got.served_id);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         psel, penable, pwrite;
  logic [lps_pkg::CFG_AW-1:0]   paddr;
  logic [lps_pkg::CFG_DW-1:0]   pwdata;
  logic [lps_pkg::CFG_DW-1:0]   prdata;
  logic                         pready;

  lps_stream_if #(.payload_t(lps_pkg::req_t)) in_chan ();
  lps_stream_if #(.payload_t(lps_pkg::rsp_t)) out_chan ();

  level_priority_scheduler u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  waiting_table tbl = new();
  int           n_floor_writes = 0;

  always #4 clk = ~clk;

  // Receiver back-pressure: an 8-bit ready pattern, replayed and reloaded each time the cycle counter wraps.
  // Bit 0 is always set so the ready pattern is never all low.
  logic [7:0] stall_pat = 8'hFF;
  logic [7:0] stall_cyc = 8'd0;

  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 8'd1;
    if (stall_cyc == 8'd0)
      stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    out_chan.ready <= stall_pat[stall_cyc[2:0]];
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      tbl.check_served(out_chan.payload);
  end

  function automatic lps_pkg::req_t mk_req(lps_pkg::req_code_t op, int id, int lvl, int inc);
    lps_pkg::req_t r;
    r.req_type  = op;
    r.entry_id  = IW'(id);
    r.level     = LW'(lvl);
    r.increment = LW'(inc);
    return r;
  endfunction

  function automatic int pick_waiting();
    int start;
    start = $urandom_range(0, NUM_IDS - 1);
    for (int k = 0; k < NUM_IDS; k++) begin
      if (tbl.waiting[(start + k) % NUM_IDS]) return (start + k) % NUM_IDS;
    end
    return start;
  endfunction

  // Mostly meaningful traffic: arrivals from a small id pool so ties and re-arrivals
  // happen often, raises and removes aimed at waiting entries, levels near the floor
  // and the cap. A small share is fully random noise.
  function automatic lps_pkg::req_t random_req();
    lps_pkg::req_t r;
    int unsigned   pick;
    r.req_type  = 2'($urandom);
    r.entry_id  = IW'($urandom);
    r.level     = LW'($urandom);
    r.increment = LW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      return r;
    end else if (pick < 30) begin
      r.req_type = lps_pkg::REQ_ARRIVE;
      if ($urandom_range(0, 1) == 0) r.entry_id = IW'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0: r.level = tbl.floor_lvl;
        1: r.level = tbl.floor_lvl - LW'(1);
        2: r.level = tbl.floor_lvl + LW'(1);
        3: r.level = LW'(MAX_LVL);
        default: ;
      endcase
    end else if (pick < 50) begin
      r.req_type = lps_pkg::REQ_RAISE;
      if ($urandom_range(0, 4) != 0) r.entry_id = IW'(pick_waiting());
      if ($urandom_range(0, 3) != 0) r.increment = LW'($urandom_range(0, 10));
    end else if (pick < 75) begin
      r.req_type = lps_pkg::REQ_REMOVE;
      if ($urandom_range(0, 4) != 0) r.entry_id = IW'(pick_waiting());
    end else begin
      r.req_type = lps_pkg::REQ_QUERY;
    end
    return r;
  endfunction

  // Called on a rising edge; returns on the edge where the beat is taken.
  task automatic send_req(input lps_pkg::req_t r);
    in_chan.payload <= r;
    in_chan.valid   <= 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    tbl.apply_request(r);
  endtask

  task automatic hold_off(input int cycles);
    in_chan.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending, let every outstanding answer arrive, then give the block time
  // to finish requests that produce no answer.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (tbl.served_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lps_pkg::CFG_AW'(idx * 4);
    pwdata  <= lps_pkg::CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == int'(lps_pkg::REG_IDX_FLOOR)) tbl.floor_lvl = LW'(value);
    n_floor_writes++;
  endtask

  task automatic run_bursts(input int n_items);
    int sent;
    int burst;
    int gap;
    int k;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < n_items; k++) begin
        send_req(random_req());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) hold_off(gap);
    end
  endtask

  initial begin
    int floor_plan [NUM_PHASES];
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.payload  <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset floor of 30.
    send_req(mk_req(lps_pkg::REQ_QUERY, 0, 0, 0));      // empty table
    send_req(mk_req(lps_pkg::REQ_ARRIVE, 0, 0, 0));
    send_req(mk_req(lps_pkg::REQ_QUERY, 0, 0, 0));      // only entry is below the floor
    send_req(mk_req(lps_pkg::REQ_ARRIVE, 63, 127, 0));  // level saturates at the cap
    send_req(mk_req(lps_pkg::REQ_ARRIVE, 5, 100, 0));
    send_req(mk_req(lps_pkg::REQ_QUERY, 0, 0, 0));      // tie at the cap, earlier arrival wins
    send_req(mk_req(lps_pkg::REQ_ARRIVE, 63, 100, 0));  // re-arrival takes a new order number
    send_req(mk_req(lps_pkg::REQ_QUERY, 0, 0, 0));
    send_req(mk_req(lps_pkg::REQ_RAISE, 0, 0, 127));    // raise saturates, keeps the old order
    send_req(mk_req(lps_pkg::REQ_QUERY, 0, 0, 0));
    send_req(mk_req(lps_pkg::REQ_REMOVE, 0, 0, 0));
    send_req(mk_req(lps_pkg::REQ_REMOVE, 0, 0, 0));     // not waiting any more
    send_req(mk_req(lps_pkg::REQ_RAISE, 0, 0, 5));      // not waiting any more
    send_req(mk_req(lps_pkg::REQ_QUERY, 0, 0, 0));
    send_req(mk_req(lps_pkg::REQ_ARRIVE, 42, 30, 0));   // exactly at the floor
    send_req(mk_req(lps_pkg::REQ_REMOVE, 5, 0, 0));
    send_req(mk_req(lps_pkg::REQ_REMOVE, 63, 0, 0));
    send_req(mk_req(lps_pkg::REQ_QUERY, 0, 0, 0));
    send_req(mk_req(lps_pkg::REQ_ARRIVE, 21, 29, 0));
    send_req(mk_req(lps_pkg::REQ_RAISE, 21, 0, 1));
    send_req(mk_req(lps_pkg::REQ_QUERY, 0, 0, 0));
    send_req(mk_req(lps_pkg::REQ_RAISE, 42, 0, 0));
    send_req(mk_req(lps_pkg::REQ_REMOVE, 42, 0, 0));
    send_req(mk_req(lps_pkg::REQ_QUERY, 0, 0, 0));
    send_req(mk_req(lps_pkg::REQ_REMOVE, 21, 0, 0));
    wait_idle();

    // 127 puts the floor above every possible level.
    floor_plan = '{0, MAX_LVL, 127, 30, $urandom_range(1, MAX_LVL - 1),
                   $urandom_range(0, MAX_LVL)};
    foreach (floor_plan[p]) begin
      cfg_write(int'(lps_pkg::REG_IDX_FLOOR), floor_plan[p]);
      @(posedge clk);
      if (p == 1) begin
        run_bursts(PHASE_ITEMS / 2);
        wait_idle();
        run_bursts(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_bursts(PHASE_ITEMS);
      end
      wait_idle();
    end

    $display("Covered %0d arrivals, %0d raises, %0d removes and %0d queries",
             tbl.n_arrive, tbl.n_raise, tbl.n_remove, tbl.n_found + tbl.n_empty);
    $display("(%0d served, %0d empty, %0d answers checked) over %0d floor settings",
             tbl.n_found, tbl.n_empty, tbl.n_checked, n_floor_writes);
    if (tbl.bad_beats == 0 && tbl.served_q.size() == 0) begin
      $display("level_priority_scheduler verification clean");
    end else begin
      $display("%0d bad result beats, %0d answers missing", tbl.bad_beats,
               tbl.served_q.size());
      $display("level_priority_scheduler verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d answers outstanding", tbl.served_q.size());
    $display("level_priority_scheduler verification failed");
    $finish;
  end

endmodule
